@@ src/pra_pkg.sv @@
`timescale 1ns / 1ps

package pra_pkg;

  // field widths
  localparam int OP_W      = 1;
  localparam int CNT_W     = 11;
  localparam int PAGE_W    = 20;
  localparam int BRK_W     = 21;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 21;

  localparam int REGION_PAGES_DEF = 1024;

  // request kinds
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;

  localparam logic [BRK_W-1:0] HEAP_LIMIT_RST = 21'd1024;
  localparam logic [BRK_W-1:0] ADDR_PAGES     = 21'h100000;

endpackage

@@ src/page_run_allocator.sv @@
`timescale 1ns / 1ps

// Page-run allocator: exact fit first, else the first largest free run, else
// the break is raised. One command at a time.
//  - Command channel: op, page_count, page_index are taken at the rising edge
//    where start is high and busy is low. busy stays high while the command
//    is worked on.
//  - Result channel: done is high for exactly one cycle with status,
//    start_page, pages_freed and break_after. Every command gives one result
//    transaction; the receiver cannot stall, so nothing waits on it.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//    only while idle. Writing the region base restarts the region.
//  - Timing: a bad request is answered straight from idle. An allocate
//    reads run-table entries for the used pages in order, then writes one
//    entry per allocated page. A free reads the entry of the freed page,
//    clears its run and walks down over trailing free pages. The run-table
//    memory has a single read and a single write port.
//  - Back to back: a command is taken only once the last is through; the
//    next may be taken while done is high.
//  - Reset: no clearing pass. A high-water mark tells which entries were ever
//    written since the last restart; entries at or above it read as free.

module page_run_allocator #(
  parameter int REGION_PAGES = pra_pkg::REGION_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [pra_pkg::OP_W-1:0]      op,
  input  logic [pra_pkg::CNT_W-1:0]     page_count,
  input  logic [pra_pkg::PAGE_W-1:0]    page_index,
  // result
  output logic                          done,
  output logic [pra_pkg::ST_W-1:0]      status,
  output logic [pra_pkg::PAGE_W-1:0]    start_page,
  output logic [pra_pkg::CNT_W-1:0]     pages_freed,
  output logic [pra_pkg::BRK_W-1:0]     break_after,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pra_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int IW = (REGION_PAGES > 1) ? $clog2(REGION_PAGES) : 1;
  localparam int PW = $clog2(REGION_PAGES + 1);
  localparam int CW = (PW > pra_pkg::CNT_W) ? PW : pra_pkg::CNT_W;
  localparam int PAGE_W = pra_pkg::PAGE_W;
  localparam int BRK_W  = pra_pkg::BRK_W;
  localparam int CNT_W  = pra_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a command
    S_SCAN,   // streaming run-table reads, tracking free runs
    S_PICK,   // worst fit or break extension
    S_MARK,   // write the run, one page a cycle
    S_FRD,    // run-table entry of the freed page arrives
    S_CLR,    // clear the run, one page a cycle
    S_WSET,   // start the walk down from the break
    S_WALK    // lower the break past trailing free pages
  } state_t;

  state_t state;

  // configuration
  logic [PAGE_W-1:0] base;
  logic [BRK_W-1:0]  limit;

  // region bookkeeping
  logic [PW-1:0]     used;      // break - base
  logic [PW-1:0]     hwm;       // entries at or above read as free

  // request context
  logic [CNT_W-1:0]  req_count;
  logic [CNT_W-1:0]  freed;
  logic [PW-1:0]     pick;
  logic [PW-1:0]     waddr;
  logic [CNT_W-1:0]  remaining;

  // read stream: issue side and data side
  logic [PW-1:0]     issue_p;
  logic              issuing;
  logic              pv;
  logic [PW-1:0]     pidx;
  logic              pterm;

  // run tracking
  logic [PW-1:0]     run;
  logic [PW-1:0]     run_start;
  logic [PW-1:0]     best;
  logic [PW-1:0]     best_start;

  // run-table memory
  logic [CNT_W-1:0]  run_mem [REGION_PAGES];
  logic [CNT_W-1:0]  mem_q;
  logic              rd_live;
  logic [PAGE_W-1:0] rd_full;
  logic [IW-1:0]     rd_addr;
  logic              rd_hit;
  logic              mem_we;
  logic [CNT_W-1:0]  mem_wdata;

  // datapath
  logic [BRK_W-1:0]  brk;
  logic [PAGE_W-1:0] rel;
  logic              free_bad;
  logic              cmd_acc;
  logic              cfg_acc;
  logic              ent_free;
  logic              ent_used;
  logic              exact_hit;
  logic              best_ok;
  logic              ext_ok;
  logic [BRK_W:0]    ext_top;
  logic [BRK_W-1:0]  lim_eff;
  logic [CW:0]       ext_room;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign cmd_acc   = start && !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign brk      = BRK_W'(base) + BRK_W'(used);
  assign rel      = page_index - base;
  assign free_bad = (page_index < base) || (rel >= PAGE_W'(REGION_PAGES));

  // data side of the read stream; a not-yet-written entry counts as free
  assign ent_free  = !pterm && (!rd_live || (mem_q == '0));
  assign ent_used  = rd_live && (mem_q != '0);
  assign exact_hit = (run != '0) && (CW'(run) == CW'(req_count));
  assign best_ok   = (best != '0) && (CW'(best) >= CW'(req_count));

  assign lim_eff  = (limit > pra_pkg::ADDR_PAGES) ? pra_pkg::ADDR_PAGES : limit;
  assign ext_top  = (BRK_W + 1)'(brk) + (BRK_W + 1)'(req_count);
  assign ext_room = (CW + 1)'(used) + (CW + 1)'(req_count);
  assign ext_ok   = (ext_top <= (BRK_W + 1)'(lim_eff)) &&
                    (ext_room <= (CW + 1)'(REGION_PAGES));

  // read address: freed page while idle, stream position otherwise
  always_comb begin
    if (state == S_IDLE) begin
      rd_full = rel;
    end else begin
      rd_full = PAGE_W'(issue_p);
    end
    rd_hit  = (rd_full < PAGE_W'(hwm));
    rd_addr = (rd_full < PAGE_W'(REGION_PAGES)) ? rd_full[IW-1:0] : '0;
  end

  assign mem_we    = (state == S_MARK) || (state == S_CLR);
  assign mem_wdata = (state == S_MARK) ? remaining : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_mem[waddr[IW-1:0]] <= mem_wdata;
    end
    mem_q   <= run_mem[rd_addr];
    rd_live <= rd_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      base    <= '0;
      limit   <= pra_pkg::HEAP_LIMIT_RST;
      used    <= '0;
      hwm     <= '0;
      issuing <= 1'b0;
      pv      <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_acc) begin
        unique case (cfg_index)
          pra_pkg::CFG_REGION_BASE: begin
            base <= cfg_data[PAGE_W-1:0];
            used <= '0;
            hwm  <= '0;
          end
          pra_pkg::CFG_HEAP_LIMIT: begin
            limit <= cfg_data[BRK_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (op == pra_pkg::OP_ALLOC) begin
              if (page_count == '0) begin
                done        <= 1'b1;
                status      <= pra_pkg::ST_BAD;
                start_page  <= '0;
                pages_freed <= '0;
                break_after <= brk;
              end else begin
                req_count <= page_count;
                issue_p   <= '0;
                issuing   <= 1'b1;
                pv        <= 1'b0;
                run       <= '0;
                best      <= '0;
                state     <= S_SCAN;
              end
            end else begin
              if (free_bad) begin
                done        <= 1'b1;
                status      <= pra_pkg::ST_BAD;
                start_page  <= '0;
                pages_freed <= '0;
                break_after <= brk;
              end else begin
                waddr <= rel[PW-1:0];
                state <= S_FRD;
              end
            end
          end
        end

        S_SCAN: begin
          // issue pages 0..used; position used is the closing terminator
          if (issuing) begin
            if (issue_p == used) begin
              issuing <= 1'b0;
            end else begin
              issue_p <= issue_p + 1'b1;
            end
          end
          pv    <= issuing;
          pidx  <= issue_p;
          pterm <= (issue_p == used);
          if (pv) begin
            if (ent_free) begin
              if (run == '0) begin
                run_start <= pidx;
              end
              run <= run + 1'b1;
            end else begin
              run <= '0;
              if (exact_hit) begin
                pick      <= run_start;
                waddr     <= run_start;
                remaining <= req_count;
                issuing   <= 1'b0;
                state     <= S_MARK;
              end else begin
                if (run > best) begin
                  best       <= run;
                  best_start <= run_start;
                end
                if (pterm) begin
                  state <= S_PICK;
                end
              end
            end
          end
        end

        S_PICK: begin
          if (best_ok) begin
            pick      <= best_start;
            waddr     <= best_start;
            remaining <= req_count;
            state     <= S_MARK;
          end else if (ext_ok) begin
            pick      <= used;
            waddr     <= used;
            remaining <= req_count;
            used      <= PW'(ext_room);
            state     <= S_MARK;
          end else begin
            done        <= 1'b1;
            status      <= pra_pkg::ST_NOSPACE;
            start_page  <= '0;
            pages_freed <= '0;
            break_after <= brk;
            state       <= S_IDLE;
          end
        end

        S_MARK: begin
          // each page holds the pages left in its run, itself included
          if (waddr >= hwm) begin
            hwm <= waddr + 1'b1;
          end
          if (remaining > CNT_W'(1)) begin
            waddr     <= waddr + 1'b1;
            remaining <= remaining - 1'b1;
          end else begin
            done        <= 1'b1;
            status      <= pra_pkg::ST_OK;
            start_page  <= base + PAGE_W'(pick);
            pages_freed <= '0;
            break_after <= brk;
            state       <= S_IDLE;
          end
        end

        S_FRD: begin
          if (ent_used) begin
            freed     <= mem_q;
            remaining <= mem_q;
            state     <= S_CLR;
          end else begin
            freed <= '0;
            state <= S_WSET;
          end
        end

        S_CLR: begin
          if ((remaining > CNT_W'(1)) && (waddr != PW'(REGION_PAGES - 1))) begin
            waddr     <= waddr + 1'b1;
            remaining <= remaining - 1'b1;
          end else begin
            state <= S_WSET;
          end
        end

        S_WSET: begin
          if (used == '0) begin
            done        <= 1'b1;
            status      <= pra_pkg::ST_OK;
            start_page  <= '0;
            pages_freed <= freed;
            break_after <= BRK_W'(base);
            state       <= S_IDLE;
          end else begin
            issue_p <= used - 1'b1;
            issuing <= 1'b1;
            pv      <= 1'b0;
            state   <= S_WALK;
          end
        end

        S_WALK: begin
          // stream reads downward from the break until a used page shows up
          if (issuing) begin
            if (issue_p == '0) begin
              issuing <= 1'b0;
            end else begin
              issue_p <= issue_p - 1'b1;
            end
          end
          pv   <= issuing;
          pidx <= issue_p;
          if (pv && (ent_used || (pidx == '0))) begin
            issuing     <= 1'b0;
            done        <= 1'b1;
            status      <= pra_pkg::ST_OK;
            start_page  <= '0;
            pages_freed <= freed;
            state       <= S_IDLE;
            if (ent_used) begin
              used        <= pidx + 1'b1;
              break_after <= BRK_W'(base) + BRK_W'(pidx + 1'b1);
            end else begin
              used        <= '0;
              break_after <= BRK_W'(base);
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // outside the mark pass the used span never passes the written span;
  // the written span never passes the region
  a_used_hwm: assert property (@(posedge clk) disable iff (rst)
    (state != S_MARK) |-> ((used <= hwm) && (CW'(hwm) <= CW'(REGION_PAGES))))
    else $error("used span beyond written span or region");

  // a result transaction always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  // an accepted command either finishes at once or keeps the block busy
  a_cmd_progress: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> (done || busy))
    else $error("command dropped");

  // failed requests report no start page
  a_fail_start: assert property (@(posedge clk) disable iff (rst)
    (done && (status != pra_pkg::ST_OK)) |-> (start_page == '0))
    else $error("start page set on a failed request");

  // only the clear pass writes zero, only the mark pass writes a count
  a_mark_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (remaining != '0))
    else $error("run written with zero length");

endmodule
